[sv/tws_pkg.sv]
`default_nettype none
package tws_pkg;

   // Transfer phases of the serial engine
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_PREP    = 3'd1,
      PH_SEND_LO = 3'd2,
      PH_SEND_HI = 3'd3,
      PH_READ_HI = 3'd4,
      PH_READ_LO = 3'd5
   } phase_type;

   // Request action codes
   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_START = 1'b1;

   localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;
   localparam logic [7:0] HALF_COUNT_MAX    = 8'd255;
   localparam logic [3:0] CMD_LAST_BIT      = 4'd7;
   localparam logic [3:0] DATA_FIRST_BIT    = 4'd8;
   localparam logic [3:0] LAST_BIT          = 4'd15;

   // One classified request as it sits in the queue
   typedef struct packed {
      logic       start;
      logic [7:0] command_byte;
      logic [7:0] write_value;
      logic       is_read;
      logic       data_pin_in;
   } item_type;

   // Queue head as seen by the engine
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage
`default_nettype wire

[sv/tws_front.sv]
`default_nettype none
module tws_front
   import tws_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_action,
   input  wire logic [7:0] req_command_byte,
   input  wire logic [7:0] req_write_value,
   input  wire logic       req_is_read,
   input  wire logic       req_data_pin_in,
   output head_type        head,
   input  wire logic       head_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   new_item;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid & ~req_stall;

   // Classify: a start versus a tick of time
   always_comb begin
      new_item.start        = (req_action == ACT_START);
      new_item.command_byte = req_command_byte;
      new_item.write_value  = req_write_value;
      new_item.is_read      = req_is_read;
      new_item.data_pin_in  = req_data_pin_in;
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ head_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

[sv/tws_engine.sv]
`default_nettype none
module tws_engine
   import tws_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data,
   input  wire head_type   head,
   output logic            head_pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_enable_pin,
   output logic            rsp_clock_pin,
   output logic            rsp_data_pin_out,
   output logic            rsp_data_pin_drive,
   output logic            rsp_busy_res,
   output logic            rsp_done_res,
   output logic [7:0]      rsp_read_value
);

   logic [7:0] half_period_ff;
   phase_type  phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] half_count_ff, half_count_in;
   logic [7:0] send_shift_ff, send_shift_in;
   logic [7:0] pending_ff, pending_in;
   logic [7:0] receive_shift_ff, receive_shift_in;
   logic       reading_ff, reading_in;
   logic       done_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       en_ff, en_in;
   logic       clk_ff, clk_in;
   logic       dout_ff, dout_in;
   logic       drv_ff, drv_in;
   logic       busy_ff, busy_in;
   logic       done_ff;
   logic [7:0] read_value_ff, read_value_in;

   logic [7:0] half_len;
   logic       half_over;
   logic [7:0] half_bumped;

   assign head_pop = head.valid & (~rsp_valid_ff | ~rsp_stall);

   assign half_len    = (half_period_ff == 8'd0) ? 8'd1 : half_period_ff;
   assign half_over   = (half_count_ff >= half_len);
   assign half_bumped = (half_count_ff < HALF_COUNT_MAX) ? half_count_ff + 8'd1
                                                         : half_count_ff;

   // Next state of the transfer
   always_comb begin
      phase_in         = phase_ff;
      bit_count_in     = bit_count_ff;
      half_count_in    = half_count_ff;
      send_shift_in    = send_shift_ff;
      pending_in       = pending_ff;
      receive_shift_in = receive_shift_ff;
      reading_in       = reading_ff;
      done_in          = 1'b0;
      if (head.item.start) begin
         if (phase_ff == PH_IDLE) begin
            send_shift_in    = head.item.command_byte;
            pending_in       = head.item.write_value;
            reading_in       = head.item.is_read;
            receive_shift_in = 8'd0;
            bit_count_in     = 4'd0;
            half_count_in    = 8'd0;
            phase_in         = PH_PREP;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
            end
            PH_PREP: begin
               bit_count_in  = 4'd0;
               phase_in      = PH_SEND_LO;
               half_count_in = 8'd1;
            end
            PH_SEND_LO: begin
               if (half_over) begin
                  phase_in      = PH_SEND_HI;
                  half_count_in = 8'd1;
               end else begin
                  half_count_in = half_bumped;
               end
            end
            PH_SEND_HI: begin
               if (!half_over) begin
                  half_count_in = half_bumped;
               end else begin
                  send_shift_in = {1'b0, send_shift_ff[7:1]};
                  if (bit_count_ff >= LAST_BIT) begin
                     phase_in      = PH_IDLE;
                     half_count_in = 8'd0;
                     done_in       = 1'b1;
                  end else if (bit_count_ff == CMD_LAST_BIT) begin
                     bit_count_in  = DATA_FIRST_BIT;
                     half_count_in = 8'd1;
                     if (reading_ff) begin
                        phase_in = PH_READ_HI;
                     end else begin
                        send_shift_in = pending_ff;
                        phase_in      = PH_SEND_LO;
                     end
                  end else begin
                     bit_count_in  = bit_count_ff + 4'd1;
                     phase_in      = PH_SEND_LO;
                     half_count_in = 8'd1;
                  end
               end
            end
            PH_READ_HI: begin
               if (half_over) begin
                  phase_in      = PH_READ_LO;
                  half_count_in = 8'd1;
               end else begin
                  half_count_in = half_bumped;
               end
            end
            PH_READ_LO: begin
               if (!half_over) begin
                  half_count_in = half_bumped;
               end else begin
                  receive_shift_in = {head.item.data_pin_in, receive_shift_ff[7:1]};
                  if (bit_count_ff >= LAST_BIT) begin
                     phase_in      = PH_IDLE;
                     half_count_in = 8'd0;
                     done_in       = 1'b1;
                  end else begin
                     bit_count_in  = bit_count_ff + 4'd1;
                     phase_in      = PH_READ_HI;
                     half_count_in = 8'd1;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Pin levels after the request
   always_comb begin
      en_in   = 1'b0;
      clk_in  = 1'b0;
      dout_in = 1'b0;
      drv_in  = 1'b0;
      case (phase_in)
         PH_SEND_LO: begin
            en_in   = 1'b1;
            drv_in  = 1'b1;
            dout_in = send_shift_in[0];
         end
         PH_SEND_HI: begin
            en_in   = 1'b1;
            clk_in  = 1'b1;
            drv_in  = 1'b1;
            dout_in = send_shift_in[0];
         end
         PH_READ_HI: begin
            en_in  = 1'b1;
            clk_in = 1'b1;
         end
         PH_READ_LO: begin
            en_in = 1'b1;
         end
         default: begin
         end
      endcase
      busy_in       = (phase_in != PH_IDLE);
      read_value_in = (done_in && reading_in) ? receive_shift_in : 8'd0;
      rsp_valid_in  = head_pop | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff   <= HALF_PERIOD_RESET;
         phase_ff         <= PH_IDLE;
         bit_count_ff     <= 4'd0;
         half_count_ff    <= 8'd0;
         send_shift_ff    <= 8'd0;
         pending_ff       <= 8'd0;
         receive_shift_ff <= 8'd0;
         reading_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            half_period_ff <= csr_write_data;
         end
         if (head_pop) begin
            phase_ff         <= phase_in;
            bit_count_ff     <= bit_count_in;
            half_count_ff    <= half_count_in;
            send_shift_ff    <= send_shift_in;
            pending_ff       <= pending_in;
            receive_shift_ff <= receive_shift_in;
            reading_ff       <= reading_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         en_ff         <= en_in;
         clk_ff        <= clk_in;
         dout_ff       <= dout_in;
         drv_ff        <= drv_in;
         busy_ff       <= busy_in;
         done_ff       <= done_in;
         read_value_ff <= read_value_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_enable_pin     = en_ff;
   assign rsp_clock_pin      = clk_ff;
   assign rsp_data_pin_out   = dout_ff;
   assign rsp_data_pin_drive = drv_ff;
   assign rsp_busy_res       = busy_ff;
   assign rsp_done_res       = done_ff;
   assign rsp_read_value     = read_value_ff;

endmodule
`default_nettype wire

[sv/three_wire_serial_master_unit.sv]
// A response is valid once its request has passed the two-entry queue and
// the response register. Throughput: one request per cycle, back to back,
//   while rsp_stall is low; the transfer state updates once per popped request.
// Reset: synchronous, active high; clears queue, transfer state and response
//   valid, and loads the half period register with 2.
`default_nettype none
module three_wire_serial_master_unit
   import tws_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration: half period length in ticks
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_action,
   input  wire logic [7:0] req_command_byte,
   input  wire logic [7:0] req_write_value,
   input  wire logic       req_is_read,
   input  wire logic       req_data_pin_in,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_enable_pin,
   output logic            rsp_clock_pin,
   output logic            rsp_data_pin_out,
   output logic            rsp_data_pin_drive,
   output logic            rsp_busy_res,
   output logic            rsp_done_res,
   output logic [7:0]      rsp_read_value
);

   // Head of the two-entry request queue and the engine's pop strobe
   head_type head;
   logic     head_pop;

   // Front: accept requests, tag starts versus ticks, and buffer up to two of
   // them while the response side stalls; once both are full, req_stall rises.
   tws_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_command_byte (req_command_byte),
      .req_write_value  (req_write_value),
      .req_is_read      (req_is_read),
      .req_data_pin_in  (req_data_pin_in),
      .head             (head),
      .head_pop         (head_pop)
   );

   // Back: advance the serial transfer one request at a time and hold each
   // response in an output register until it is taken.
   tws_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .head               (head),
      .head_pop           (head_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_enable_pin     (rsp_enable_pin),
      .rsp_clock_pin      (rsp_clock_pin),
      .rsp_data_pin_out   (rsp_data_pin_out),
      .rsp_data_pin_drive (rsp_data_pin_drive),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_read_value     (rsp_read_value)
   );

endmodule
`default_nettype wire

[tb/tb_three_wire_serial_master_unit.sv]
`timescale 1ns / 1ps
module tb_three_wire_serial_master_unit;
   import tws_pkg::*;

   // Pin levels and status carried by one response
   typedef struct packed {
      logic       enable_pin;
      logic       clock_pin;
      logic       data_pin_out;
      logic       data_pin_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_value;
   } pin_levels_type;

   // Where a directed row takes its expected levels from
   typedef enum {LV_MODEL, LV_QUIET, LV_PREP} levels_src_type;
   typedef enum {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      int             reps;
      item_type       it;
      logic [7:0]     csr_value;
      levels_src_type src;
   } plan_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_action = ACT_TICK;
   logic [7:0] req_command_byte = 8'd0;
   logic [7:0] req_write_value = 8'd0;
   logic       req_is_read = 1'b0;
   logic       req_data_pin_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_enable_pin;
   logic       rsp_clock_pin;
   logic       rsp_data_pin_out;
   logic       rsp_data_pin_drive;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_read_value;

   three_wire_serial_master_unit uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_command_byte   (req_command_byte),
      .req_write_value    (req_write_value),
      .req_is_read        (req_is_read),
      .req_data_pin_in    (req_data_pin_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_enable_pin     (rsp_enable_pin),
      .rsp_clock_pin      (rsp_clock_pin),
      .rsp_data_pin_out   (rsp_data_pin_out),
      .rsp_data_pin_drive (rsp_data_pin_drive),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_read_value     (rsp_read_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the serial engine: half period register and transfer state
   logic [7:0] half_ticks;
   phase_type  link_phase;
   logic [3:0] link_bit;
   logic [7:0] link_half;
   logic [7:0] link_tx;
   logic [7:0] link_pending;
   logic [7:0] link_rx;
   logic       link_reading;

   pin_levels_type expected_levels[$];
   int             mismatch_count = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;

   // Step the shadow engine by one accepted request and return the levels it shows.
   task automatic predict_levels(input item_type it, output pin_levels_type lv);
      logic [7:0] half_len;
      logic       over;
      logic       done;
      done = 1'b0;
      half_len = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
      over = (link_half >= half_len);
      if (it.start == ACT_START) begin
         // a start only latches when idle; while busy it is dropped outright
         if (link_phase == PH_IDLE) begin
            link_tx = it.command_byte;
            link_pending = it.write_value;
            link_reading = it.is_read;
            link_rx = 8'd0;
            link_bit = 4'd0;
            link_half = 8'd0;
            link_phase = PH_PREP;
         end
      end else if (link_phase != PH_IDLE) begin
         case (link_phase)
            PH_PREP: begin
               link_bit = 4'd0;
               link_phase = PH_SEND_LO;
               link_half = 8'd1;
            end
            PH_SEND_LO, PH_READ_HI: begin
               if (over) begin
                  link_phase = (link_phase == PH_SEND_LO) ? PH_SEND_HI : PH_READ_LO;
                  link_half = 8'd1;
               end else if (link_half < HALF_COUNT_MAX) begin
                  link_half = link_half + 8'd1;
               end
            end
            PH_SEND_HI: begin
               if (!over) begin
                  if (link_half < HALF_COUNT_MAX) link_half = link_half + 8'd1;
               end else begin
                  link_tx = link_tx >> 1;
                  if (link_bit >= LAST_BIT) begin
                     link_phase = PH_IDLE;
                     link_half = 8'd0;
                     done = 1'b1;
                  end else if (link_bit == CMD_LAST_BIT) begin
                     // command is out: turn to the data byte or release the line
                     link_bit = DATA_FIRST_BIT;
                     link_half = 8'd1;
                     if (link_reading) begin
                        link_phase = PH_READ_HI;
                     end else begin
                        link_tx = link_pending;
                        link_phase = PH_SEND_LO;
                     end
                  end else begin
                     link_bit = link_bit + 4'd1;
                     link_phase = PH_SEND_LO;
                     link_half = 8'd1;
                  end
               end
            end
            PH_READ_LO: begin
               if (!over) begin
                  if (link_half < HALF_COUNT_MAX) link_half = link_half + 8'd1;
               end else begin
                  // sample at the end of the low half, shift in at the MSB
                  link_rx = {it.data_pin_in, link_rx[7:1]};
                  if (link_bit >= LAST_BIT) begin
                     link_phase = PH_IDLE;
                     link_half = 8'd0;
                     done = 1'b1;
                  end else begin
                     link_bit = link_bit + 4'd1;
                     link_phase = PH_READ_HI;
                     link_half = 8'd1;
                  end
               end
            end
            default: link_phase = PH_IDLE;
         endcase
      end

      lv = '0;
      case (link_phase)
         PH_SEND_LO: begin
            lv.enable_pin = 1'b1;
            lv.data_pin_drive = 1'b1;
            lv.data_pin_out = link_tx[0];
         end
         PH_SEND_HI: begin
            lv.enable_pin = 1'b1;
            lv.clock_pin = 1'b1;
            lv.data_pin_drive = 1'b1;
            lv.data_pin_out = link_tx[0];
         end
         PH_READ_HI: begin
            lv.enable_pin = 1'b1;
            lv.clock_pin = 1'b1;
         end
         PH_READ_LO: lv.enable_pin = 1'b1;
         default: ;
      endcase
      lv.busy_res = (link_phase != PH_IDLE);
      lv.done_res = done;
      lv.read_value = (done && link_reading) ? link_rx : 8'd0;
   endtask

   // Drive one request at the falling edge, hold it until taken, then record its levels.
   task automatic send_request(input item_type it, input levels_src_type src);
      pin_levels_type lv;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_action = it.start;
      req_command_byte = it.command_byte;
      req_write_value = it.write_value;
      req_is_read = it.is_read;
      req_data_pin_in = it.data_pin_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_levels(it, lv);
      // typed rows keep the shadow in step but check against the written levels
      if (src == LV_QUIET) begin
         lv = '0;
      end else if (src == LV_PREP) begin
         lv = '0;
         lv.busy_res = 1'b1;
      end
      expected_levels.push_back(lv);
      @(negedge clock);
   endtask

   // Drop valid and wait until every response owed has come back.
   task automatic drain_responses();
      req_valid = 1'b0;
      while (expected_levels.size() != 0) @(negedge clock);
   endtask

   task automatic write_half_period(input logic [7:0] value);
      drain_responses();
      csr_write_data = value;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      half_ticks = value;
   endtask

   function automatic plan_row_type req_row(input logic act, input logic [7:0] cmd,
                                            input logic [7:0] wv, input logic rd,
                                            input logic pin, input int reps,
                                            input levels_src_type src);
      plan_row_type r;
      r.kind = ROW_REQUEST;
      r.reps = reps;
      r.it.start = act;
      r.it.command_byte = cmd;
      r.it.write_value = wv;
      r.it.is_read = rd;
      r.it.data_pin_in = pin;
      r.csr_value = 8'd0;
      r.src = src;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [7:0] value);
      plan_row_type r;
      r.kind = ROW_CSR;
      r.reps = 0;
      r.it = '0;
      r.csr_value = value;
      r.src = LV_MODEL;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare every accepted response with the oldest expectation.
   always @(posedge clock) begin : check_response
      pin_levels_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_levels.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_levels.pop_front();
            check_field("enable_pin", 8'(want.enable_pin), 8'(rsp_enable_pin));
            check_field("clock_pin", 8'(want.clock_pin), 8'(rsp_clock_pin));
            check_field("data_pin_out", 8'(want.data_pin_out), 8'(rsp_data_pin_out));
            check_field("data_pin_drive", 8'(want.data_pin_drive),
                        8'(rsp_data_pin_drive));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
            check_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
            check_field("read_value", want.read_value, rsp_read_value);
         end
      end
   end

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock)
      rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      plan_row_type plan[$];
      item_type     it;
      logic [7:0]   seg_half[6];
      half_ticks = HALF_PERIOD_RESET;
      link_phase = PH_IDLE;
      link_bit = 4'd0;
      link_half = 8'd0;
      link_tx = 8'd0;
      link_pending = 8'd0;
      link_rx = 8'd0;
      link_reading = 1'b0;

      // hold reset from time zero, release on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: full write and read at the shortest half period, zero
      // half period, start while busy, and the longest half period cut short
      // by a register change in the middle of a transfer.
      plan.push_back(csr_row(8'd1));
      plan.push_back(req_row(ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b1, 1, LV_QUIET));
      plan.push_back(req_row(ACT_START, 8'hFF, 8'h00, 1'b0, 1'b0, 1, LV_PREP));
      plan.push_back(req_row(ACT_START, 8'h00, 8'hFF, 1'b1, 1'b1, 1, LV_PREP));
      plan.push_back(req_row(ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 33, LV_MODEL));
      plan.push_back(req_row(ACT_TICK, 8'hFF, 8'hFF, 1'b1, 1'b0, 1, LV_QUIET));
      plan.push_back(req_row(ACT_START, 8'h00, 8'hFF, 1'b1, 1'b0, 1, LV_PREP));
      plan.push_back(req_row(ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b1, 33, LV_MODEL));
      plan.push_back(csr_row(8'd0));
      plan.push_back(req_row(ACT_START, 8'hA5, 8'h5A, 1'b1, 1'b0, 1, LV_PREP));
      plan.push_back(req_row(ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 34, LV_MODEL));
      plan.push_back(csr_row(8'd255));
      plan.push_back(req_row(ACT_START, 8'h5A, 8'hC3, 1'b0, 1'b0, 1, LV_PREP));
      plan.push_back(req_row(ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b1, 20, LV_MODEL));
      plan.push_back(csr_row(8'd1));
      plan.push_back(req_row(ACT_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 40, LV_MODEL));
      plan.push_back(csr_row(HALF_PERIOD_RESET));

      send_idle_pct = 18;
      recv_idle_pct = 45;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_half_period(plan[i].csr_value);
         end else begin
            repeat (plan[i].reps) send_request(plan[i].it, plan[i].src);
         end
      end

      // Random part: six segments, two per idling pattern, each at its own
      // half period. The register write drains first, so one segment's
      // transfer may still be running when the next one changes the timing.
      seg_half[0] = 8'd1;
      seg_half[1] = 8'd2;
      seg_half[2] = 8'd1;
      seg_half[3] = 8'($urandom_range(1, 4));
      seg_half[4] = 8'd1;
      seg_half[5] = 8'd3;
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin send_idle_pct = 18; recv_idle_pct = 45; end
            1: begin send_idle_pct = 45; recv_idle_pct = 18; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         write_half_period(seg_half[seg]);
         for (int n = 0; n < 180; n++) begin
            // start soon after going idle; rare starts mid-transfer are noise
            if (link_phase == PH_IDLE)
               it.start = ($urandom_range(9) < 7) ? ACT_START : ACT_TICK;
            else
               it.start = ($urandom_range(99) < 4) ? ACT_START : ACT_TICK;
            it.command_byte = 8'($urandom_range(255));
            it.write_value = 8'($urandom_range(255));
            it.is_read = 1'($urandom_range(1));
            it.data_pin_in = 1'($urandom_range(1));
            send_request(it, LV_MODEL);
         end
      end

      drain_responses();
      recv_idle_pct = 0;
      // keep watching for stray responses before the verdict
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && expected_levels.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
sv/tws_pkg.sv
sv/tws_front.sv
sv/tws_engine.sv
sv/three_wire_serial_master_unit.sv
tb/tb_three_wire_serial_master_unit.sv
